// ===== src/ising_pkg.sv =====
// shared types, constants and widths of the ising metropolis lattice
package ising_pkg;

    localparam int COORD_W = 6;
    localparam int SIDE    = 1 << COORD_W;
    localparam int RAND_W  = 32;
    localparam int ENER_W  = 15;
    localparam int MAG_W   = 14;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic signed [ENER_W-1:0] ENER_RESET = ENER_W'(-2 * SIDE * SIDE);
    localparam logic signed [MAG_W-1:0]  MAG_RESET  = MAG_W'(SIDE * SIDE);

    localparam logic OP_FLIP = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic REG_THRESH_2 = 1'b0;
    localparam logic REG_THRESH_4 = 1'b1;

    typedef enum logic [1:0] {
        RD_UP,
        RD_MID,
        RD_DN
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_up;
        logic    cap_mid;
        logic    commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [RAND_W-1:0] thresh_2;
        logic [RAND_W-1:0] thresh_4;
    } t_cfg;

endpackage

// ===== src/ising_regs.sv =====
// apb register file holding the two acceptance thresholds
module ising_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ising_pkg::ADDR_W-1:0] paddr,
    input  logic [ising_pkg::DATA_W-1:0] pwdata,
    output logic [ising_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output ising_pkg::t_cfg             o_cfg
);
    import ising_pkg::*;

    logic [RAND_W-1:0] r_thresh_2, n_thresh_2;
    logic [RAND_W-1:0] r_thresh_4, n_thresh_4;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_comb begin
        n_thresh_2 = r_thresh_2;
        n_thresh_4 = r_thresh_4;
        if (wr_en) begin
            case (reg_sel)
                REG_THRESH_2: n_thresh_2 = pwdata;
                REG_THRESH_4: n_thresh_4 = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh_2 <= '0;
            r_thresh_4 <= '0;
        end else begin
            r_thresh_2 <= n_thresh_2;
            r_thresh_4 <= n_thresh_4;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_THRESH_2: prdata = r_thresh_2;
            REG_THRESH_4: prdata = r_thresh_4;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.thresh_2 = r_thresh_2;
    assign o_cfg.thresh_4 = r_thresh_4;

endmodule

// ===== src/ising_ctrl.sv =====
// sequencer for the three row reads and the write-back of one item
module ising_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output ising_pkg::t_ctrl_cmd o_cmd
);
    import ising_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MID  = 4'b0010,
        S_DN   = 4'b0100,
        S_EVAL = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load: 1'b0, rd_en: 1'b0, rd_sel: RD_UP,
                    cap_up: 1'b0, cap_mid: 1'b0, commit: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_UP;
                    n_state      = S_MID;
                end
            end
            S_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_MID;
                o_cmd.cap_up = 1'b1;
                n_state      = S_DN;
            end
            S_DN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_DN;
                o_cmd.cap_mid = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/ising_dp.sv =====
// lattice row memory, neighbour evaluation and running totals
module ising_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ising_pkg::t_ctrl_cmd                  i_cmd,
    input  ising_pkg::t_cfg                       i_cfg,
    input  logic                                  i_op,
    input  logic [ising_pkg::COORD_W-1:0]         i_row,
    input  logic [ising_pkg::COORD_W-1:0]         i_col,
    input  logic [ising_pkg::RAND_W-1:0]          i_rand_fraction,
    input  logic                                  i_spin_value,
    output logic                                  o_done,
    output logic                                  o_spin_after,
    output logic                                  o_flipped,
    output logic signed [ising_pkg::ENER_W-1:0]   o_total_energy,
    output logic signed [ising_pkg::MAG_W-1:0]    o_magnetization
);
    import ising_pkg::*;

    localparam logic [COORD_W-1:0] LAST = COORD_W'(SIDE - 1);

    // one row of spins per entry, 1 = +1
    logic [SIDE-1:0] r_mem [SIDE];
    logic [SIDE-1:0] r_row_vld;

    logic              r_op;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [RAND_W-1:0] r_rand;
    logic              r_want;

    logic [COORD_W-1:0] row_src;
    logic [COORD_W-1:0] rd_addr;
    logic [SIDE-1:0]    r_rd_data;
    logic               r_rd_vld;
    logic [SIDE-1:0]    rd_row;
    logic [SIDE-1:0]    r_up_row;
    logic [SIDE-1:0]    r_mid_row;

    logic [COORD_W-1:0] col_l, col_r;
    logic               s_bit, nb_up, nb_dn, nb_l, nb_r;
    logic [2:0]         eq_cnt;
    logic               change;
    logic [SIDE-1:0]    new_row;
    logic signed [6:0]  e_delta;
    logic signed [MAG_W-1:0] m_delta;

    logic signed [ENER_W-1:0] r_energy;
    logic signed [MAG_W-1:0]  r_magnet;
    logic                     r_done;
    logic                     r_spin_after;
    logic                     r_flipped;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_row  <= i_row;
            r_col  <= i_col;
            r_rand <= i_rand_fraction;
            r_want <= i_spin_value;
        end
    end

    assign row_src = i_cmd.load ? i_row : r_row;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_UP:   rd_addr = (row_src == '0) ? LAST : row_src - 1'b1;
            RD_MID:  rd_addr = row_src;
            RD_DN:   rd_addr = (row_src == LAST) ? '0 : row_src + 1'b1;
            default: rd_addr = row_src;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
        if (i_cmd.commit) begin
            r_mem[r_row] <= new_row;
        end
    end

    // a row never written reads as all spins up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.commit) begin
            r_row_vld[r_row] <= 1'b1;
        end
    end

    assign rd_row = r_rd_vld ? r_rd_data : '1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_up)  r_up_row  <= rd_row;
        if (i_cmd.cap_mid) r_mid_row <= rd_row;
    end

    // neighbour evaluation, down row comes straight from the read port
    assign col_l = (r_col == '0) ? LAST : r_col - 1'b1;
    assign col_r = (r_col == LAST) ? '0 : r_col + 1'b1;

    assign s_bit = r_mid_row[r_col];
    assign nb_up = r_up_row[r_col];
    assign nb_dn = rd_row[r_col];
    assign nb_l  = r_mid_row[col_l];
    assign nb_r  = r_mid_row[col_r];

    assign eq_cnt = 3'(nb_up ~^ s_bit) + 3'(nb_dn ~^ s_bit)
                  + 3'(nb_l ~^ s_bit) + 3'(nb_r ~^ s_bit);

    always_comb begin
        if (r_op == OP_SET) begin
            change = (r_want != s_bit);
        end else if (eq_cnt <= 3'd2) begin
            change = 1'b1;
        end else if (eq_cnt == 3'd3) begin
            change = (r_rand < i_cfg.thresh_2);
        end else begin
            change = (r_rand < i_cfg.thresh_4);
        end
    end

    always_comb begin
        new_row        = r_mid_row;
        new_row[r_col] = s_bit ^ change;
    end

    // energy moves by 2*sum = 4*eq - 8, magnetization by -2*s
    assign e_delta = $signed({2'b00, eq_cnt, 2'b00}) - 7'sd8;
    assign m_delta = s_bit ? -MAG_W'(2) : MAG_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= ENER_RESET;
            r_magnet <= MAG_RESET;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit && change) begin
                r_energy <= r_energy + ENER_W'(e_delta);
                r_magnet <= r_magnet + m_delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_spin_after <= s_bit ^ change;
            r_flipped    <= change;
        end
    end

    assign o_done          = r_done;
    assign o_spin_after    = r_spin_after;
    assign o_flipped       = r_flipped;
    assign o_total_energy  = r_energy;
    assign o_magnetization = r_magnet;

endmodule

// ===== src/ising_metropolis_lattice.sv =====
// top level of the 2d ising metropolis lattice engine
// the accepting edge latches the item and reads the row above; the result is loaded at the
// write-back edge, and o_done is high in the cycle after it; a new item is taken
// only once the last is written back, as each one needs three row reads through the single
// read port of the lattice row memory (up, centre, down) and one write-back of the centre row
// synchronous active-low reset: all spins +1, energy -2*SIDE^2, magnetization SIDE^2,
// thresholds 0; the receiver cannot stall, each result is shown for one cycle only
module ising_metropolis_lattice (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_op,
    input  logic [ising_pkg::COORD_W-1:0]         i_row,
    input  logic [ising_pkg::COORD_W-1:0]         i_col,
    input  logic [ising_pkg::RAND_W-1:0]          i_rand_fraction,
    input  logic                                  i_spin_value,
    // result channel
    output logic                                  o_done,
    output logic                                  o_spin_after,
    output logic                                  o_flipped,
    output logic signed [ising_pkg::ENER_W-1:0]   o_total_energy,
    output logic signed [ising_pkg::MAG_W-1:0]    o_magnetization,
    // apb configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ising_pkg::ADDR_W-1:0]          paddr,
    input  logic [ising_pkg::DATA_W-1:0]          pwdata,
    output logic [ising_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);
    import ising_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_cfg      cfg;
    logic      ctrl_busy;

    // thresholds at byte address 0 and 4; paddr bit 2 picks the register
    ising_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // a transfer is taken when start is high while the sequencer is idle;
    // in that same cycle the row above the site is already being read
    ising_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (ctrl_busy),
        .o_cmd   (ctrl_cmd)
    );

    assign busy = ctrl_busy;

    // lattice rows live in a memory with one valid bit per row, so reset
    // needs no clearing pass: an unwritten row reads as all spins up.
    // totals are updated from the neighbour sum, never recounted
    ising_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .i_cfg           (cfg),
        .i_op            (i_op),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_rand_fraction (i_rand_fraction),
        .i_spin_value    (i_spin_value),
        .o_done          (o_done),
        .o_spin_after    (o_spin_after),
        .o_flipped       (o_flipped),
        .o_total_energy  (o_total_energy),
        .o_magnetization (o_magnetization)
    );

endmodule
